/* hdl/rhht_pkg.sv */
package rhht_pkg;
  localparam int TABLE_BITS = 10;
  localparam int TABLE_SIZE = 1 << TABLE_BITS;
  localparam int KEY_BYTES  = 8;
  localparam int LEN_W      = 10;
  localparam int CFG_W      = 10;
  localparam int SLOT_W     = 1 + TABLE_BITS + 64 + 64;
  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_MUL   = 64'h00000100000001b3;
  localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(700);

  typedef logic [TABLE_BITS-1:0] idx_t;

  typedef struct packed {
    logic       valid;
    idx_t       home;
    logic [63:0] key;
    logic [63:0] value;
  } slot_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch request, start hash
    logic hash_step; // one FNV byte
    logic rd;        // issue slot read at probe index
    logic eval;      // evaluate registered slot
    logic wr;        // write computed slot
    logic adv;       // step probe index
    logic clr;       // clearing pass write
    logic fin;       // capture result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hash_done;
    logic stop;      // probe ends at this slot
    logic need_wr;   // slot must be written
    logic clr_done;
  } sts_t;
endpackage

/* hdl/rhht_if.sv */
interface rhht_req_if;
  import rhht_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] key;
  logic [63:0] value;
  modport source (output valid, req_type, key, value, input ready);
  modport sink (input valid, req_type, key, value, output ready);
endinterface

interface rhht_rsp_if;
  import rhht_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic [63:0]      old_value;
  logic             status;
  logic [LEN_W-1:0] probe_length;
  modport source (output valid, found, old_value, status, probe_length, input ready);
  modport sink (input valid, found, old_value, status, probe_length, output ready);
endinterface

/* hdl/rhht_ram.sv */
module rhht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/rhht_ctrl.sv */
module rhht_ctrl
  import rhht_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HASH = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_EVAL = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;

  // a finished result sits in the output register while the next request hashes
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r;
    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end
    unique case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_done) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        // results leave one at a time: wait for the output register to drain
        if (!(sts.stop && ovalid_r && !out_ready)) begin
          cmd.eval = 1'b1;
          cmd.wr   = sts.need_wr;
          if (sts.stop) begin
            cmd.fin    = 1'b1;
            ovalid_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            cmd.adv   = 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end
endmodule

/* hdl/rhht_dp.sv */
module rhht_dp
  import rhht_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [1:0]       in_req_type,
  input  logic [63:0]      in_key,
  input  logic [63:0]      in_value,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output logic             out_found,
  output logic [63:0]      out_old_value,
  output logic             out_status,
  output logic [LEN_W-1:0] out_probe_length
);
  localparam int BCNT_W = $clog2(KEY_BYTES + 1);

  logic [CFG_W-1:0]  lim_r;
  logic [1:0]        req_r;
  logic [63:0]       raw_r, key_r, val_r, hash_r;
  logic [63:0]       ckey_r, cval_r;
  idx_t              chome_r, idx_r, clr_r;
  logic [BCNT_W-1:0] bcnt_r;
  logic              hend_r, placed_r, clr_done_r;
  logic [TABLE_BITS:0] steps_r;
  logic [CFG_W-1:0]  count_r;
  logic [63:0]       hx, prod;
  logic [7:0]        byte_c;
  slot_t             rd_slot, wr_slot;
  logic              we;
  idx_t              waddr;

  logic              open_c, hit_c, disp_c, stop_c, wr_c;
  logic [TABLE_BITS-1:0] dcur, dres;
  logic [CFG_W-1:0]  lim_eff;
  logic [LEN_W-1:0]  plen_c;

  // result of the request in progress, copied to the output register at the end
  logic              found_r, found_nxt, status_r, status_nxt;
  logic [63:0]       old_r, old_nxt;
  logic [LEN_W-1:0]  plen_r, plen_nxt;

  assign byte_c = raw_r[7:0];
  // FNV prime is 2^40 + 0x1b3: shift and add
  assign hx     = hash_r ^ {56'd0, byte_c};
  assign prod   = (hx << 40) + (hx << 8) + (hx << 7) + (hx << 5) + (hx << 4) + (hx << 1) + hx;

  // effective limit clamped to [1, TABLE_SIZE-1]
  always_comb begin
    lim_eff = lim_r;
    if (lim_eff == '0) lim_eff = CFG_W'(1);
    if (32'(lim_eff) > TABLE_SIZE - 1) lim_eff = CFG_W'(TABLE_SIZE - 1);
  end

  always_comb begin
    open_c = !rd_slot.valid;
    hit_c  = rd_slot.valid && !placed_r && (rd_slot.key == key_r);
    dcur   = idx_r - chome_r;
    dres   = idx_r - rd_slot.home;
    disp_c = rd_slot.valid && !hit_c && (dcur > dres);
    stop_c = 1'b0;
    wr_c   = 1'b0;
    wr_slot = '{valid: 1'b1, home: chome_r, key: ckey_r, value: cval_r};
    if (hit_c) begin
      stop_c = 1'b1;
      wr_c   = req_r[0];
      wr_slot = '{valid: 1'b1, home: rd_slot.home, key: rd_slot.key, value: val_r};
    end else if ((open_c || disp_c) && !placed_r &&
                 (!req_r[1] || count_r >= lim_eff)) begin
      stop_c = 1'b1;
    end else if (open_c || disp_c) begin
      wr_c   = 1'b1;
      stop_c = open_c;
    end
    if (!placed_r && 32'(steps_r) > 1023) plen_c = LEN_W'(1023);
    else plen_c = LEN_W'(steps_r);
  end

  always_comb begin
    found_nxt  = found_r;
    old_nxt    = old_r;
    status_nxt = status_r;
    plen_nxt   = plen_r;
    if (!placed_r && (hit_c || open_c || disp_c)) begin
      plen_nxt = plen_c;
    end
    if (hit_c) begin
      found_nxt = 1'b1;
      old_nxt   = rd_slot.value;
    end else if (stop_c && !wr_c && !placed_r) begin
      status_nxt = req_r[1];
    end
  end

  assign we    = cmd.clr || (cmd.wr);
  assign waddr = cmd.clr ? clr_r : idx_r;

  rhht_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_SIZE)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (cmd.clr ? '0 : SLOT_W'(wr_slot)),
    .raddr (idx_r),
    .rdata (rd_slot)
  );

  assign sts.hash_done = hend_r;
  assign sts.stop      = stop_c;
  assign sts.need_wr   = wr_c;
  assign sts.clr_done  = clr_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r      <= LIMIT_RESET;
      count_r    <= '0;
      clr_r      <= '0;
      clr_done_r <= 1'b0;
    end else begin
      if (cfg_we) lim_r <= cfg_wdata;
      if (cmd.clr) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == idx_t'(TABLE_SIZE - 2)) clr_done_r <= 1'b1;
      end
      if (cmd.eval && wr_c && open_c) count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req_type;
      raw_r  <= in_key;
      val_r  <= in_value;
      key_r  <= '0;
      hash_r <= FNV_BASIS;
      bcnt_r <= '0;
      hend_r <= 1'b0;
    end
    if (cmd.hash_step && !hend_r) begin
      if (byte_c == 8'd0 || 32'(bcnt_r) >= KEY_BYTES - 1) begin
        hend_r <= 1'b1;
      end
      if (byte_c != 8'd0) begin
        hash_r <= prod;
        key_r  <= key_r | ({56'd0, byte_c} << (8 * bcnt_r));
      end
      raw_r  <= raw_r >> 8;
      bcnt_r <= bcnt_r + 1'b1;
    end
    if (cmd.hash_step && hend_r) begin
      idx_r    <= hash_r[TABLE_BITS-1:0];
      chome_r  <= hash_r[TABLE_BITS-1:0];
      ckey_r   <= key_r;
      cval_r   <= val_r;
      steps_r  <= '0;
      placed_r <= 1'b0;
      found_r  <= 1'b0;
      old_r    <= '0;
      status_r <= 1'b0;
    end
    if (cmd.eval) begin
      found_r  <= found_nxt;
      old_r    <= old_nxt;
      status_r <= status_nxt;
      plen_r   <= plen_nxt;
      if (wr_c && !hit_c) begin
        placed_r <= 1'b1;
        if (disp_c) begin
          chome_r <= rd_slot.home;
          ckey_r  <= rd_slot.key;
          cval_r  <= rd_slot.value;
        end
      end
    end
    if (cmd.fin) begin
      out_found        <= found_nxt;
      out_old_value    <= old_nxt;
      out_status       <= status_nxt;
      out_probe_length <= plen_nxt;
    end
    if (cmd.adv) begin
      idx_r   <= idx_r + 1'b1;
      steps_r <= steps_r + 1'b1;
    end
  end
endmodule

/* hdl/robin_hood_hash_table.sv */
// Robin Hood hash table, 1024 slots, 64-bit keys and values.
// in_*  : request channel (valid/ready), fields req_type, key, value.
// out_* : result channel (valid/ready), fields found, old_value, status,
//         probe_length; one result per request, in order.
// cfg_* : write enable and data for max_entries (load limit), reset 700.
// Hashing: FNV-1a, one byte per cycle (shift-and-add multiply by the FNV prime),
// ends at the first zero byte or after the eighth byte; then each slot visited on
// the slot RAM (one read port, one write port) passes through the states read,
// wait for registered data, and evaluate with write back. The next request can
// be taken in the same cycle that the result becomes valid.
// One request is worked at a time; a new request is taken while the last
// result still waits in the output register, and a stalled receiver holds
// the block only when the next result is ready.
// After reset all 1024 slots of the table RAM are cleared, one slot per cycle,
// during which in_ready stays low; configuration writes are taken anytime.
module robin_hood_hash_table
  import rhht_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  rhht_req_if.sink         in_req,
  rhht_rsp_if.source       out_rsp,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);
  cmd_t cmd;
  sts_t sts;

  rhht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rhht_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_type      (in_req.req_type),
    .in_key           (in_req.key),
    .in_value         (in_req.value),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_found        (out_rsp.found),
    .out_old_value    (out_rsp.old_value),
    .out_status       (out_rsp.status),
    .out_probe_length (out_rsp.probe_length)
  );
endmodule

/* hdl/rhht_checker.sv */
module rhht_checker
  import rhht_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_found,
  input logic             out_status,
  input logic [63:0]      out_old_value
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped under stall");
  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_status))
    else $error("refused request reports a hit");
  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_old_value == 64'd0)
    else $error("miss carries nonzero old value");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");
endmodule

bind robin_hood_hash_table rhht_checker u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_req.valid),
  .in_ready      (in_req.ready),
  .out_valid     (out_rsp.valid),
  .out_ready     (out_rsp.ready),
  .out_found     (out_rsp.found),
  .out_status    (out_rsp.status),
  .out_old_value (out_rsp.old_value)
);
